>>> rtl/handheld_console_timer_assert.svh
// Assertion macros for the handheld console timer.
// Expects clk and rst_n in scope at the point of use.
`ifndef HANDHELD_CONSOLE_TIMER_ASSERT_SVH
`define HANDHELD_CONSOLE_TIMER_ASSERT_SVH

// same-cycle implication
`define HCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hct_pkg.sv
// Shared types and constants for the handheld console timer.
// No dependencies.
`timescale 1ns / 1ps

package hct_pkg;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] SEL_DIV  = 2'd0;
    localparam logic [1:0] SEL_TIMA = 2'd1;
    localparam logic [1:0] SEL_TMA  = 2'd2;
    localparam logic [1:0] SEL_TAC  = 2'd3;

    localparam logic [1:0] RATE_1024 = 2'd0;
    localparam logic [1:0] RATE_16   = 2'd1;
    localparam logic [1:0] RATE_64   = 2'd2;
    localparam logic [1:0] RATE_256  = 2'd3;

    localparam int TAC_EN_BIT = 2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] cycles;
        logic [1:0] reg_sel;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic due;
    } status_t;

    function automatic logic [10:0] tima_period(input logic [1:0] rate);
        logic [10:0] p;
        unique case (rate)
            RATE_16:  p = 11'd16;
            RATE_64:  p = 11'd64;
            RATE_256: p = 11'd256;
            default:  p = 11'd1024;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/handheld_console_timer.sv
// Handheld console timer top level: DIV, TIMA, TMA and TAC behind a word channel.
// Depends on hct_pkg, hct_ctrl and hct_dp.
`timescale 1ns / 1ps

// One request word at a time, one response word per request. A register read or
// write is taken and its response is offered in the cycle after; the block
// stays busy until that response is taken, which an output stall can delay.
// A tick makes N TIMA steps, where N is the number of steps its cycles produce:
// TIMA advances once per clock while a step is due, through a single prescaler
// subtract and incrementer. With the fastest rate N is at most 4 per tick, but
// after TAC is changed to a shorter period the next tick may step up to 67 times.
// A new request is accepted once the previous response has been taken.

module handheld_console_timer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  hct_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output hct_pkg::rsp_t rsp
);
    import hct_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    req_tick;

    assign req_tick = (req.req_type == REQ_TICK);

    hct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_tick  (req_tick),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    hct_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .status (status),
        .rsp    (rsp)
    );

endmodule

>>> rtl/hct_dp.sv
// Timer datapath: DIV/TIMA/TMA/TAC registers, prescalers, result word.
// Depends on hct_pkg.
`timescale 1ns / 1ps

module hct_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  hct_pkg::cmd_t    cmd,
    input  hct_pkg::req_t    req,
    output hct_pkg::status_t status,
    output hct_pkg::rsp_t    rsp
);
    import hct_pkg::*;

    logic [8:0]  div_pre_reg,  div_pre_next;
    logic [7:0]  div_reg,      div_next;
    logic [10:0] tima_pre_reg, tima_pre_next;
    logic [7:0]  tima_reg,     tima_next;
    logic [7:0]  tma_reg,      tma_next;
    logic [2:0]  tac_reg,      tac_next;
    logic [7:0]  rdata_reg,    rdata_next;
    logic        irq_reg,      irq_next;

    logic [9:0]  div_sum;
    logic [11:0] tima_sum;
    logic [10:0] period;
    logic [7:0]  read_mux;

    assign period     = tima_period(tac_reg[1:0]);
    assign status.due = tac_reg[TAC_EN_BIT] && (tima_pre_reg >= period);
    assign div_sum    = {1'b0, div_pre_reg} + {4'd0, req.cycles};
    assign tima_sum   = {1'b0, tima_pre_reg} + {6'd0, req.cycles};

    always_comb
    begin
        unique case (req.reg_sel)
            SEL_DIV:  read_mux = div_reg;
            SEL_TIMA: read_mux = tima_reg;
            SEL_TMA:  read_mux = tma_reg;
            default:  read_mux = {5'd0, tac_reg};
        endcase
    end

    always_comb
    begin
        div_pre_next  = div_pre_reg;
        div_next      = div_reg;
        tima_pre_next = tima_pre_reg;
        tima_next     = tima_reg;
        tma_next      = tma_reg;
        tac_next      = tac_reg;
        rdata_next    = rdata_reg;
        irq_next      = irq_reg;

        if (cmd.load)
        begin
            rdata_next = 8'd0;
            irq_next   = 1'b0;
            if (cmd.tick)
            begin
                if (div_sum >= 10'd256)
                begin
                    div_pre_next = 9'(div_sum - 10'd256);
                    div_next     = div_reg + 8'd1;
                end
                else
                begin
                    div_pre_next = div_sum[8:0];
                end
                if (tac_reg[TAC_EN_BIT])
                begin
                    tima_pre_next = tima_sum[10:0];
                end
            end
            else if (req.req_type == REQ_READ)
            begin
                rdata_next = read_mux;
            end
            else if (req.req_type == REQ_WRITE)
            begin
                unique case (req.reg_sel)
                    SEL_DIV:
                    begin
                        div_next     = 8'd0;
                        div_pre_next = 9'd0;
                    end
                    SEL_TIMA: tima_next = req.write_data;
                    SEL_TMA:  tma_next  = req.write_data;
                    default:  tac_next  = req.write_data[2:0];
                endcase
            end
        end
        else if (cmd.step)
        begin
            tima_pre_next = tima_pre_reg - period;
            if (tima_reg == 8'hff)
            begin
                tima_next = tma_reg;
                irq_next  = 1'b1;
            end
            else
            begin
                tima_next = tima_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_pre_reg  <= '0;
            div_reg      <= '0;
            tima_pre_reg <= '0;
            tima_reg     <= '0;
            tma_reg      <= '0;
            tac_reg      <= '0;
        end
        else
        begin
            div_pre_reg  <= div_pre_next;
            div_reg      <= div_next;
            tima_pre_reg <= tima_pre_next;
            tima_reg     <= tima_next;
            tma_reg      <= tma_next;
            tac_reg      <= tac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        irq_reg   <= irq_next;
    end

    assign rsp.read_data = rdata_reg;
    assign rsp.timer_irq = irq_reg;

endmodule

>>> rtl/hct_ctrl.sv
// Timer controller: sequences word accept, TIMA stepping and result handoff.
// Depends on hct_pkg and handheld_console_timer_assert.svh.
`timescale 1ns / 1ps
`include "handheld_console_timer_assert.svh"

module hct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_tick,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  hct_pkg::status_t status,
    output hct_pkg::cmd_t    cmd
);
    import hct_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = req_tick ? ST_STEP : ST_OUT;
                end
            end
            ST_STEP:
            begin
                if (!status.due)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        rsp_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
                cmd.tick  = req_tick;
            end
            ST_STEP:
            begin
                cmd.step = status.due;
            end
            ST_OUT:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `HCT_ASSERT_NOW(a_one_at_a_time, rsp_valid, req_stall, "result pending while accepting")
    `HCT_ASSERT_NOW(a_step_in_loop, cmd.step, state_reg == ST_STEP && !cmd.load, "stray step")
    `HCT_ASSERT_NEXT(a_load_leaves_idle, cmd.load, state_reg != ST_IDLE, "load did not start")
    `HCT_ASSERT_NEXT(a_read_no_loop, cmd.load && !cmd.tick, rsp_valid, "access skipped result")

endmodule
